>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_core; no other dependencies.
package spq_pkg;

   // Fixed field widths of the request and response ports
   localparam int VALUE_WIDTH     = 32;
   localparam int PRIO_PORT_WIDTH = 8;
   localparam int OCC_WIDTH       = 5;
   localparam int STATUS_WIDTH    = 2;

   // Defaults for the top-level parameters
   localparam int DEFAULT_CAPACITY      = 16;
   localparam int DEFAULT_PRIORITY_BITS = 8;

   // Request mode codes
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spq_status_type;

   // Chain-wide operation broadcast to every cell
   typedef struct packed {
      logic insert;   // accepted enqueue into a non-full queue
      logic remove;   // accepted dequeue from a non-empty queue
   } spq_op_type;

endpackage

>>> hdl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: command port, cell chain, count.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Requests enter on req_mode / req_value / req_priority_req and are taken at
//   a rising edge with start high and busy low. busy is always low here: the
//   chain of cells completes each request at the edge that takes it, so a new
//   request may be issued every cycle.
//   req_mode selects enqueue or dequeue. An enqueue lands behind every stored
//   entry of equal or higher priority; a dequeue removes the head entry.
//   Every request produces one response, driven on rsp_data / rsp_status /
//   rsp_occupancy and marked by rsp_valid for exactly one cycle, in the cycle
//   after the request was taken (throughput 1 request per cycle).
//   The receiver cannot hold responses off and need not: one response leaves
//   per cycle at most.
//   Status reports queue empty on dequeue and queue full on enqueue; in both
//   cases the stored entries are untouched and rsp_data is zero.
//   Only the low PRIORITY_BITS bits of req_priority_req are compared.
//   Synchronous reset empties the queue; no clearing pass.
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY      = DEFAULT_CAPACITY,
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [PRIO_PORT_WIDTH-1:0]    req_priority_req,
   output logic                          rsp_valid,
   output logic signed [VALUE_WIDTH-1:0] rsp_data,
   output logic [STATUS_WIDTH-1:0]       rsp_status,
   output logic [OCC_WIDTH-1:0]          rsp_occupancy
);

   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   logic [31:0]              prio_wide;
   logic [PRIORITY_BITS-1:0] new_prio;
   spq_op_type               op;

   logic [CNT_WIDTH-1:0]     count_ff, count_in;
   logic [31:0]              count_wide;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]        rsp_data_ff, rsp_data_in;
   spq_status_type                rsp_status_ff, rsp_status_in;
   logic [OCC_WIDTH-1:0]          rsp_occ_ff, rsp_occ_in;

   logic                     cell_keep  [CAPACITY];
   logic                     cell_valid [CAPACITY];
   logic [VALUE_WIDTH-1:0]   cell_value [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // priority port narrowed or widened to the stored width
   assign prio_wide = {{(32 - PRIO_PORT_WIDTH){1'b0}}, req_priority_req};
   assign new_prio  = prio_wide[PRIORITY_BITS-1:0];

   assign is_full  = (count_ff == CNT_WIDTH'(CAPACITY));
   assign is_empty = !cell_valid[0];

   // operation broadcast to the chain
   assign op.insert = accept && (req_mode == MODE_ENQUEUE) && !is_full;
   assign op.remove = accept && (req_mode == MODE_DEQUEUE) && !is_empty;

   // chain of cells, head at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                     p_keep, p_valid, n_valid;
      logic [VALUE_WIDTH-1:0]   p_value, n_value;
      logic [PRIORITY_BITS-1:0] p_prio, n_prio;

      if (i == 0) begin : g_head
         assign p_keep  = 1'b1;
         assign p_valid = 1'b0;
         assign p_value = '0;
         assign p_prio  = '0;
      end else begin : g_body
         assign p_keep  = cell_keep[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_value = cell_value[i-1];
         assign p_prio  = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_value = '0;
         assign n_prio  = '0;
      end else begin : g_mid
         assign n_valid = cell_valid[i+1];
         assign n_value = cell_value[i+1];
         assign n_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_value  (req_value),
         .new_prio   (new_prio),
         .prev_keep  (p_keep),
         .prev_valid (p_valid),
         .prev_value (p_value),
         .prev_prio  (p_prio),
         .next_valid (n_valid),
         .next_value (n_value),
         .next_prio  (n_prio),
         .keep       (cell_keep[i]),
         .valid      (cell_valid[i]),
         .value      (cell_value[i]),
         .prio       (cell_prio[i])
      );
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (op.insert) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (op.remove) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   assign count_wide = {{(32 - CNT_WIDTH){1'b0}}, count_in};

   // response for the request taken this cycle
   always_comb begin
      rsp_valid_in  = accept;
      rsp_data_in   = '0;
      rsp_status_in = STATUS_OK;
      rsp_occ_in    = count_wide[OCC_WIDTH-1:0];
      if (req_mode == MODE_DEQUEUE) begin
         if (is_empty) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_data_in = cell_value[0];
         end
      end else if (is_full) begin
         rsp_status_in = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades with its neighbors.
// Depends on spq_pkg for the operation struct and value width.
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_op_type               op,
   // entry being inserted, broadcast to all cells
   input  logic [VALUE_WIDTH-1:0]   new_value,
   input  logic [PRIORITY_BITS-1:0] new_prio,
   // neighbor toward the head
   input  logic                     prev_keep,
   input  logic                     prev_valid,
   input  logic [VALUE_WIDTH-1:0]   prev_value,
   input  logic [PRIORITY_BITS-1:0] prev_prio,
   // neighbor toward the tail
   input  logic                     next_valid,
   input  logic [VALUE_WIDTH-1:0]   next_value,
   input  logic [PRIORITY_BITS-1:0] next_prio,
   // this cell's contents
   output logic                     keep,
   output logic                     valid,
   output logic [VALUE_WIDTH-1:0]   value,
   output logic [PRIORITY_BITS-1:0] prio
);

   logic                     valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]   value_ff, value_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;

   // entry stays put on insert when it ranks at or above the new one
   assign keep = valid_ff && (prio_ff >= new_prio);

   // next-state selection: hold, take new entry, shift back, shift forward
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (op.insert) begin
         if (!keep) begin
            if (prev_keep) begin
               valid_in = 1'b1;
               value_in = new_value;
               prio_in  = new_prio;
            end else begin
               valid_in = prev_valid;
               value_in = prev_value;
               prio_in  = prev_prio;
            end
         end
      end else if (op.remove) begin
         valid_in = next_valid;
         value_in = next_value;
         prio_in  = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset; gated by valid
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign prio  = prio_ff;

endmodule
